[sv/akwwt_pkg.sv]
package akwwt_pkg;

	// default sizing
	localparam int ENTRIES_DEF = 16;
	localparam int WAITERS_DEF = 4;
	// most results one request may report
	localparam int MAX_RESULTS = 64;

	// command codes
	localparam logic [1:0] CMD_WAIT    = 2'd0;
	localparam logic [1:0] CMD_WAKE    = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NO_ROOM = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] process_id;
		logic [63:0] wait_address;
		logic [1:0]  op_mode;
		logic [31:0] expected_generation;
		logic [7:0]  wake_limit;
		logic [15:0] waiter_handle;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        parked;
		logic        handle_valid;
		logic [15:0] out_handle;
		logic        last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic check;
		logic scan;
		logic idx_inc;
		logic meta_rd;
		logic fifo_rd;
		logic pop;
		logic wait_exec;
		logic wake_end;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       bad;
		logic [1:0] command;
		logic       match;
		logic       last_idx;
		logic       pop_ok;
		logic       cnt_zero;
	} dp_stat_t;

endpackage

[sv/akwwt_ram.sv]
module akwwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/akwwt_ctrl.sv]
module akwwt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  akwwt_pkg::dp_stat_t  stat,
	output logic                 busy,
	output akwwt_pkg::ctrl_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_CMP   = 4'd3;
	localparam logic [3:0] W_EXEC  = 4'd4;
	localparam logic [3:0] W_CHK   = 4'd5;
	localparam logic [3:0] P_RD    = 4'd6;
	localparam logic [3:0] P_PUT   = 4'd7;
	localparam logic [3:0] W_END   = 4'd8;
	localparam logic [3:0] R_RD    = 4'd9;
	localparam logic [3:0] R_CMP   = 4'd10;
	localparam logic [3:0] R_CHK   = 4'd11;
	localparam logic [3:0] R_FRD   = 4'd12;
	localparam logic [3:0] R_PUT   = 4'd13;
	localparam logic [3:0] R_NXT   = 4'd14;
	localparam logic [3:0] S_FIN   = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.bad) state_d = S_FIN;
				else if (stat.command == akwwt_pkg::CMD_RELEASE) state_d = R_RD;
				else state_d = S_RD;
			end
			S_RD: begin
				cmd.meta_rd = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				cmd.scan = 1'b1;
				if (stat.match || stat.last_idx) begin
					state_d = (stat.command == akwwt_pkg::CMD_WAIT) ? W_EXEC : W_CHK;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			W_EXEC: begin
				cmd.wait_exec = 1'b1;
				state_d       = S_FIN;
			end
			W_CHK: begin
				state_d = stat.pop_ok ? P_RD : W_END;
			end
			P_RD: begin
				cmd.fifo_rd = 1'b1;
				state_d     = P_PUT;
			end
			P_PUT: begin
				cmd.pop = 1'b1;
				state_d = W_CHK;
			end
			W_END: begin
				cmd.wake_end = 1'b1;
				state_d      = S_FIN;
			end
			R_RD: begin
				cmd.meta_rd = 1'b1;
				state_d     = R_CMP;
			end
			R_CMP: begin
				cmd.scan = 1'b1;
				state_d  = stat.match ? R_CHK : R_NXT;
			end
			R_CHK: begin
				state_d = stat.cnt_zero ? R_NXT : R_FRD;
			end
			R_FRD: begin
				cmd.fifo_rd = 1'b1;
				state_d     = R_PUT;
			end
			R_PUT: begin
				cmd.pop = 1'b1;
				state_d = R_CHK;
			end
			R_NXT: begin
				if (stat.last_idx) begin
					state_d = S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = R_RD;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[sv/akwwt_dp.sv]
module akwwt_dp #(
	parameter int ENTRIES = akwwt_pkg::ENTRIES_DEF,
	parameter int WAITERS = akwwt_pkg::WAITERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  akwwt_pkg::request_t  request,
	input  akwwt_pkg::ctrl_cmd_t cmd,
	output akwwt_pkg::dp_stat_t  stat,
	output akwwt_pkg::result_t   result,
	output logic                 result_valid
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int HW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
	localparam int CW = $clog2(WAITERS + 1);
	localparam int SW = CW + 1;
	localparam int PW = $clog2(akwwt_pkg::MAX_RESULTS + 1);

	typedef struct packed {
		logic [15:0]   process;
		logic [63:0]   address;
		logic          credit;
		logic [31:0]   generation;
		logic [CW-1:0] count;
		logic [HW-1:0] head;
	} meta_t;

	localparam int MW = $bits(meta_t);

	// request and entry state
	akwwt_pkg::request_t req_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       ent_q;
	logic                found_q;
	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic                credit_q;
	logic [31:0]         gen_q;
	logic [CW-1:0]       cnt_q;
	logic [HW-1:0]       slot_q;
	logic [CW-1:0]       woken_q;
	logic [1:0]          st_q;
	logic                parked_q;
	logic                pend_v_q;
	logic [15:0]         pend_h_q;
	logic [PW-1:0]       put_cnt_q;
	akwwt_pkg::result_t  result_q;
	logic                result_valid_q;

	logic [MW-1:0]       meta_rdata;
	meta_t               meta_rd;
	logic [15:0]         fifo_rdata;

	logic                key_hit;
	logic                match;
	logic [7:0]          limit_eff;
	logic                woken_lt;
	logic [HW-1:0]       slot_next;
	logic [SW-1:0]       tail_sum;
	logic [SW-1:0]       tail_wrap;
	logic [HW-1:0]       tail_slot;
	logic                e_idle;
	logic                gen_miss;
	logic                gen_none;
	logic                take;
	logic                full;
	logic [IW-1:0]       wait_ent;
	logic                absorb;
	logic                credit_n;
	logic                put_ok;

	logic                meta_we;
	logic [IW-1:0]       meta_wa;
	meta_t               meta_wd;
	logic                fifo_we;
	logic                valid_set;
	logic                valid_clr;
	logic [IW-1:0]       valid_idx;
	logic                no_room;
	logic                park;

	assign meta_rd  = meta_t'(meta_rdata);
	assign key_hit  = (meta_rd.process == req_q.process_id) &&
	                  ((req_q.command == akwwt_pkg::CMD_RELEASE) ||
	                   (meta_rd.address == req_q.wait_address));
	assign match    = valid_q[idx_q] && key_hit;

	assign limit_eff = (req_q.wake_limit == 8'd0) ? 8'(WAITERS) : req_q.wake_limit;
	assign woken_lt  = 8'(woken_q) < limit_eff;
	assign slot_next = (slot_q == HW'(WAITERS - 1)) ? '0 : slot_q + 1'b1;

	// fifo slot behind the last waiter
	assign tail_sum  = SW'(slot_q) + SW'(cnt_q);
	assign tail_wrap = (tail_sum >= SW'(WAITERS)) ? tail_sum - SW'(WAITERS) : tail_sum;
	assign tail_slot = tail_wrap[HW-1:0];

	assign e_idle   = (cnt_q == '0) && !credit_q;
	assign gen_miss = !req_q.op_mode[0] && found_q &&
	                  (gen_q != req_q.expected_generation);
	assign gen_none = !req_q.op_mode[0] && !found_q &&
	                  (req_q.expected_generation != 32'd0);
	assign take     = req_q.op_mode[0] && found_q && credit_q;
	assign full     = (!found_q && !free_found_q) || (cnt_q >= CW'(WAITERS)) ||
	                  (req_q.waiter_handle == 16'd0);
	assign wait_ent = found_q ? ent_q : free_idx_q;
	assign absorb   = woken_lt && req_q.op_mode[0];
	assign credit_n = absorb || credit_q;
	assign put_ok   = put_cnt_q < PW'(akwwt_pkg::MAX_RESULTS);

	always_comb begin
		meta_we   = 1'b0;
		meta_wa   = ent_q;
		meta_wd   = '{process: req_q.process_id, address: req_q.wait_address,
		              credit: credit_q, generation: gen_q, count: cnt_q, head: slot_q};
		fifo_we   = 1'b0;
		valid_set = 1'b0;
		valid_clr = 1'b0;
		valid_idx = ent_q;
		no_room   = 1'b0;
		park      = 1'b0;
		if (cmd.scan) begin
			valid_idx = idx_q;
			valid_clr = match && (req_q.command == akwwt_pkg::CMD_RELEASE);
		end else if (cmd.wait_exec) begin
			priority if (gen_miss) begin
				valid_clr = e_idle;
			end else if (take) begin
				meta_we        = 1'b1;
				meta_wd.credit = 1'b0;
				valid_clr      = (cnt_q == '0);
			end else if (gen_none) begin
				// no entry and the generation has already moved on
				park = 1'b0;
			end else if (full) begin
				no_room   = 1'b1;
				valid_clr = found_q && e_idle;
			end else begin
				park          = 1'b1;
				fifo_we       = 1'b1;
				meta_we       = 1'b1;
				meta_wa       = wait_ent;
				meta_wd.count = cnt_q + 1'b1;
				valid_set     = 1'b1;
				valid_idx     = wait_ent;
			end
		end else if (cmd.wake_end) begin
			// a fresh entry gets generation one since gen_q starts at zero
			meta_wd.credit     = credit_n;
			meta_wd.generation = gen_q + 32'd1;
			meta_we   = found_q || (absorb && free_found_q);
			meta_wa   = found_q ? ent_q : free_idx_q;
			valid_idx = found_q ? ent_q : free_idx_q;
			valid_set = !found_q && absorb && free_found_q;
			valid_clr = found_q && (cnt_q == '0) && !credit_n;
			no_room   = !found_q && absorb && !free_found_q;
		end
	end

	akwwt_ram #(.WIDTH(MW), .DEPTH(1 << IW)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_wa),
		.wdata (meta_wd),
		.re    (cmd.meta_rd),
		.raddr (idx_q),
		.rdata (meta_rdata)
	);

	akwwt_ram #(.WIDTH(16), .DEPTH(1 << (IW + HW))) u_fifo (
		.clk   (clk),
		.we    (fifo_we),
		.waddr ({wait_ent, tail_slot}),
		.wdata (req_q.waiter_handle),
		.re    (cmd.fifo_rd),
		.raddr ({ent_q, slot_q}),
		.rdata (fifo_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			found_q        <= 1'b0;
			free_found_q   <= 1'b0;
			pend_v_q       <= 1'b0;
			put_cnt_q      <= '0;
			st_q           <= akwwt_pkg::ST_OK;
			parked_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (cmd.pop && put_ok && pend_v_q) || cmd.finish;
			if (valid_set) valid_q[valid_idx] <= 1'b1;
			if (valid_clr) valid_q[valid_idx] <= 1'b0;
			if (cmd.load) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				pend_v_q     <= 1'b0;
				put_cnt_q    <= '0;
				st_q         <= akwwt_pkg::ST_OK;
				parked_q     <= 1'b0;
			end
			if (cmd.check && stat.bad) st_q <= akwwt_pkg::ST_INVALID;
			if (no_room) st_q <= akwwt_pkg::ST_NO_ROOM;
			if (park) parked_q <= 1'b1;
			if (cmd.scan) begin
				if (match) found_q <= 1'b1;
				if (!valid_q[idx_q] && !free_found_q) free_found_q <= 1'b1;
			end
			if (cmd.pop && put_ok) begin
				put_cnt_q <= put_cnt_q + 1'b1;
				pend_v_q  <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= request;
			idx_q    <= '0;
			credit_q <= 1'b0;
			gen_q    <= '0;
			cnt_q    <= '0;
			slot_q   <= '0;
			woken_q  <= '0;
		end
		if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
		if (cmd.scan) begin
			if (match) begin
				ent_q    <= idx_q;
				credit_q <= meta_rd.credit;
				gen_q    <= meta_rd.generation;
				cnt_q    <= meta_rd.count;
				slot_q   <= meta_rd.head;
			end
			if (!valid_q[idx_q] && !free_found_q) free_idx_q <= idx_q;
		end
		if (cmd.pop) begin
			cnt_q   <= cnt_q - 1'b1;
			woken_q <= woken_q + 1'b1;
			slot_q  <= slot_next;
			if (put_ok) begin
				pend_h_q <= fifo_rdata;
				if (pend_v_q) begin
					result_q <= '{status: akwwt_pkg::ST_OK, parked: 1'b0, handle_valid: 1'b1,
					              out_handle: pend_h_q, last: 1'b0};
				end
			end
		end
		if (cmd.finish) begin
			result_q <= '{status: st_q, parked: parked_q, handle_valid: pend_v_q,
			              out_handle: pend_v_q ? pend_h_q : 16'd0, last: 1'b1};
		end
	end

	assign stat.bad      = (req_q.command != akwwt_pkg::CMD_RELEASE) &&
	                       ((req_q.command == akwwt_pkg::CMD_NONE) ||
	                        (req_q.wait_address == 64'd0) || req_q.op_mode[1]);
	assign stat.command  = req_q.command;
	assign stat.match    = match;
	assign stat.last_idx = (idx_q == IW'(ENTRIES - 1));
	assign stat.pop_ok   = found_q && woken_lt && (cnt_q != '0);
	assign stat.cnt_zero = (cnt_q == '0);

	assign result       = result_q;
	assign result_valid = result_valid_q;

	a_mid_has_handle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.last |->
		result_q.handle_valid && (result_q.status == akwwt_pkg::ST_OK))
		else $error("non-final result without handle");

	a_park_wait_ok: assert property (@(posedge clk) disable iff (!arst_n)
		parked_q |-> (req_q.command == akwwt_pkg::CMD_WAIT) && (st_q == akwwt_pkg::ST_OK))
		else $error("parked outside a successful wait");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.scan, cmd.wait_exec, cmd.wake_end, cmd.pop, cmd.finish}))
		else $error("overlapping datapath actions");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_valid_q && result_q.last)
		else $error("finish gave no final result");

endmodule

[sv/address_keyed_wait_wake_table.sv]
// channel   | ports                          | handshake
// ----------+--------------------------------+-----------------------------------
// request   | start, busy, request            | taken when start high, busy low
// result    | result_valid, result            | single-cycle strobe per result, no back-pressure
//
// wait scans the entries up to the first hit (all of them on a miss); wake does
// the same scan and then pops waiters; release scans every entry and drops the
// handles queued on each entry of the process. the registered read of the
// metadata memory splits each scan step into a read state and a compare state.
// results come out of a one-deep look-ahead buffer so the last one can carry
// status; result_valid strobes for one cycle and the receiver cannot stall.
// reset clears the entry valid bits and the control state, not the memories; no clearing pass is needed.
module address_keyed_wait_wake_table #(
	parameter int ENTRIES = akwwt_pkg::ENTRIES_DEF,
	parameter int WAITERS = akwwt_pkg::WAITERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  akwwt_pkg::request_t request,
	output logic                result_valid,
	output akwwt_pkg::result_t  result
);

	// command and status between controller and datapath
	akwwt_pkg::ctrl_cmd_t cmd;
	akwwt_pkg::dp_stat_t  stat;

	// sequencer: check, scan, wait, pop and finish steps
	akwwt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// entry table, waiter queues and result buffer
	akwwt_dp #(.ENTRIES(ENTRIES), .WAITERS(WAITERS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

[tb/address_keyed_wait_wake_table_checker.sv]
module address_keyed_wait_wake_table_checker #(
	parameter int ENTRIES = akwwt_pkg::ENTRIES_DEF,
	parameter int WAITERS = akwwt_pkg::WAITERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  akwwt_pkg::request_t request,
	input  logic                result_valid,
	input  akwwt_pkg::result_t  result,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the wait table
	logic        tbl_valid [ENTRIES];
	logic [15:0] tbl_proc [ENTRIES];
	logic [63:0] tbl_addr [ENTRIES];
	logic        tbl_credit [ENTRIES];
	logic [31:0] tbl_gen [ENTRIES];
	int          tbl_cnt [ENTRIES];
	logic [15:0] tbl_fifo [ENTRIES][WAITERS];

	akwwt_pkg::result_t due_results [$];

	function automatic int seek_entry(logic [15:0] pid, logic [63:0] addr);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_proc[i] == pid && tbl_addr[i] == addr)
				return i;
		return -1;
	endfunction

	function automatic int claim_entry(logic [15:0] pid, logic [63:0] addr);
		for (int i = 0; i < ENTRIES; i++)
			if (!tbl_valid[i]) begin
				tbl_valid[i] = 1'b1;
				tbl_proc[i] = pid;
				tbl_addr[i] = addr;
				tbl_credit[i] = 1'b0;
				tbl_gen[i] = '0;
				tbl_cnt[i] = 0;
				return i;
			end
		return -1;
	endfunction

	function automatic void drop_if_idle(int e);
		if (e >= 0 && tbl_valid[e] && tbl_cnt[e] == 0 && !tbl_credit[e])
			tbl_valid[e] = 1'b0;
	endfunction

	function automatic void push_handle(ref akwwt_pkg::result_t out_q[$],
			input logic [15:0] h);
		akwwt_pkg::result_t r;
		if (out_q.size() >= akwwt_pkg::MAX_RESULTS)
			return;
		r = '0;
		r.handle_valid = 1'b1;
		r.out_handle = h;
		out_q.push_back(r);
	endfunction

	// predicts the results of one request and updates the shadow table
	function automatic void predict_request(akwwt_pkg::request_t rq);
		akwwt_pkg::result_t out_q [$];
		akwwt_pkg::result_t r;
		logic [1:0] st;
		logic pk;
		int e;
		int lim;
		int woken;
		st = akwwt_pkg::ST_INVALID;
		pk = 1'b0;
		unique case (rq.command)
			akwwt_pkg::CMD_WAIT: begin
				if (rq.wait_address != 0 && rq.op_mode <= 2'd1) begin
					e = seek_entry(rq.process_id, rq.wait_address);
					st = akwwt_pkg::ST_OK;
					if (rq.op_mode == 2'd0 && e >= 0 && tbl_gen[e] != rq.expected_generation)
						drop_if_idle(e);
					else if (rq.op_mode == 2'd0 && e < 0 && rq.expected_generation != 0)
						st = akwwt_pkg::ST_OK;
					else if (rq.op_mode == 2'd1 && e >= 0 && tbl_credit[e]) begin
						tbl_credit[e] = 1'b0;
						drop_if_idle(e);
					end else begin
						if (e < 0)
							e = claim_entry(rq.process_id, rq.wait_address);
						if (e < 0)
							st = akwwt_pkg::ST_NO_ROOM;
						else if (tbl_cnt[e] >= WAITERS || rq.waiter_handle == 0) begin
							drop_if_idle(e);
							st = akwwt_pkg::ST_NO_ROOM;
						end else begin
							tbl_fifo[e][tbl_cnt[e]] = rq.waiter_handle;
							tbl_cnt[e]++;
							pk = 1'b1;
						end
					end
				end
			end
			akwwt_pkg::CMD_WAKE: begin
				if (rq.wait_address != 0 && rq.op_mode <= 2'd1) begin
					st = akwwt_pkg::ST_OK;
					woken = 0;
					e = seek_entry(rq.process_id, rq.wait_address);
					lim = (rq.wake_limit == 0) ? WAITERS : int'(rq.wake_limit);
					if (e >= 0) begin
						tbl_gen[e] = tbl_gen[e] + 32'd1;
						while (woken < lim && tbl_cnt[e] != 0) begin
							push_handle(out_q, tbl_fifo[e][0]);
							for (int i = 1; i < tbl_cnt[e]; i++)
								tbl_fifo[e][i-1] = tbl_fifo[e][i];
							tbl_cnt[e]--;
							woken++;
						end
					end
					if (woken < lim && rq.op_mode == 2'd1) begin
						if (e < 0) begin
							e = claim_entry(rq.process_id, rq.wait_address);
							if (e >= 0)
								tbl_gen[e] = 32'd1;
							else
								st = akwwt_pkg::ST_NO_ROOM;
						end
						if (e >= 0)
							tbl_credit[e] = 1'b1;
					end
					if (st == akwwt_pkg::ST_OK)
						drop_if_idle(e);
				end
			end
			akwwt_pkg::CMD_RELEASE: begin
				st = akwwt_pkg::ST_OK;
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && tbl_proc[i] == rq.process_id) begin
						for (int w = 0; w < tbl_cnt[i]; w++)
							push_handle(out_q, tbl_fifo[i][w]);
						tbl_valid[i] = 1'b0;
					end
			end
			default: st = akwwt_pkg::ST_INVALID;
		endcase
		if (out_q.size() == 0) begin
			r = '0;
			out_q.push_back(r);
		end
		r = out_q[$];
		r.status = st;
		r.parked = pk;
		r.last = 1'b1;
		out_q[out_q.size()-1] = r;
		foreach (out_q[i])
			due_results.push_back(out_q[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		akwwt_pkg::result_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
			for (int i = 0; i < ENTRIES; i++)
				tbl_valid[i] = 1'b0;
			due_results.delete();
			pending <= 0;
		end else begin
			// results first: a request taken at this edge cannot have produced any yet
			if (result_valid) begin
				if (due_results.size() == 0) begin
					$error("unexpected result %p", result);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = due_results.pop_front();
					if (result.status !== exp_r.status)
						$error("status expected %0d actual %0d", exp_r.status, result.status);
					if (result.parked !== exp_r.parked)
						$error("parked expected %0d actual %0d", exp_r.parked, result.parked);
					if (result.handle_valid !== exp_r.handle_valid)
						$error("handle_valid expected %0d actual %0d",
							exp_r.handle_valid, result.handle_valid);
					if (result.out_handle !== exp_r.out_handle)
						$error("out_handle expected %0h actual %0h",
							exp_r.out_handle, result.out_handle);
					if (result.last !== exp_r.last)
						$error("last expected %0d actual %0d", exp_r.last, result.last);
					if (result !== exp_r)
						fail_count <= fail_count + 1;
				end
			end
			if (start && !busy)
				predict_request(request);
			pending <= due_results.size();
		end
	end

endmodule

[tb/address_keyed_wait_wake_table_test.sv]
module address_keyed_wait_wake_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	akwwt_pkg::request_t request = '0;
	logic                result_valid;
	akwwt_pkg::result_t  result;
	int                  fail_count;
	int                  pending;
	int                  idle_cycles = 0;

	always #4 clk = ~clk;

	address_keyed_wait_wake_table u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result_valid(result_valid), .result(result)
	);

	address_keyed_wait_wake_table_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result_valid(result_valid), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	// watchdog: cycles with nothing accepted on either side
	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[address_keyed_wait_wake_table] ERROR");
			$finish;
		end
	end

	// small key pool so entries collide, fill and get reused
	function automatic logic [63:0] pick_addr();
		unique case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return {$urandom, $urandom};
			2: return 64'hFFFF_FFFF_FFFF_FFFF;
			default: return 64'h1000 + 64'($urandom_range(0, 5)) * 8;
		endcase
	endfunction

	function automatic logic [15:0] pick_pid();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return 16'($urandom_range(1, 3));
	endfunction

	// drive one request at the falling edge and hold until taken
	task automatic send_request(akwwt_pkg::request_t rq);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request <= rq;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_fields(logic [1:0] cmd, logic [15:0] pid, logic [63:0] addr,
			logic [1:0] mode, logic [31:0] gen, logic [7:0] lim, logic [15:0] h);
		akwwt_pkg::request_t rq;
		rq.command = cmd;
		rq.process_id = pid;
		rq.wait_address = addr;
		rq.op_mode = mode;
		rq.expected_generation = gen;
		rq.wake_limit = lim;
		rq.waiter_handle = h;
		send_request(rq);
	endtask

	initial begin
		akwwt_pkg::request_t rq;
		int kind;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd0, 32'd0, 8'd0, 16'h0001);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd0, 32'd0, 8'd0, 16'hFFFF);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd0, 32'd5, 8'd0, 16'h0003);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h2000, 2'd0, 32'hFFFF_FFFF, 8'd0,
			16'h0004);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd0, 32'd0, 8'd0, 16'h0000);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd1, 32'd0, 8'd0, 16'h0005);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd1, 32'd0, 8'd0, 16'h0006);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd1, 32'd0, 8'd0, 16'h0007);
		send_fields(akwwt_pkg::CMD_WAKE, 16'd1, 64'h1000, 2'd0, 32'd0, 8'd1, 16'h0);
		send_fields(akwwt_pkg::CMD_WAKE, 16'd1, 64'h1000, 2'd1, 32'd0, 8'd0, 16'h0);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd1, 32'd0, 8'd0, 16'h0008);
		send_fields(akwwt_pkg::CMD_WAKE, 16'd2, 64'hFFFF_FFFF_FFFF_FFFF, 2'd1, 32'd0,
			8'd255, 16'h0);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd2, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 32'd1,
			8'd0, 16'h0009);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd0, 64'd0, 2'd0, 32'd0, 8'd0, 16'h000A);
		send_fields(akwwt_pkg::CMD_WAIT, 16'd1, 64'h1000, 2'd2, 32'd0, 8'd0, 16'h000B);
		send_fields(akwwt_pkg::CMD_WAKE, 16'd1, 64'h1000, 2'd3, 32'd0, 8'd0, 16'h0);
		send_fields(akwwt_pkg::CMD_WAKE, 16'd1, 64'd0, 2'd0, 32'd0, 8'd0, 16'h0);
		send_fields(akwwt_pkg::CMD_NONE, 16'hFFFF, 64'h1000, 2'd3, 32'hFFFF_FFFF, 8'd255,
			16'hFFFF);
		// fill the table to exercise out of room
		for (int i = 0; i < 17; i++)
			send_fields(akwwt_pkg::CMD_WAKE, 16'hFFFF, 64'h8000 + 64'(i), 2'd1, 32'd0,
				8'd0, 16'h0);
		send_fields(akwwt_pkg::CMD_WAIT, 16'hFFFF, 64'h9000, 2'd0, 32'd0, 8'd0, 16'h0010);
		send_fields(akwwt_pkg::CMD_RELEASE, 16'hFFFF, 64'd0, 2'd3, 32'd0, 8'd0, 16'h0);
		send_fields(akwwt_pkg::CMD_RELEASE, 16'd1, 64'h5, 2'd0, 32'd0, 8'd0, 16'h0);
		send_fields(akwwt_pkg::CMD_RELEASE, 16'd2, 64'h0, 2'd0, 32'd0, 8'd0, 16'h0);

		// random part: waits most often, then wakes, releases and bad commands, with plausible generations
		for (int n = 0; n < 330; n++) begin
			rq.command = 2'($urandom_range(0, 2));
			kind = $urandom_range(0, 19);
			if (kind == 0)
				rq.command = akwwt_pkg::CMD_NONE;
			else if (kind < 10)
				rq.command = akwwt_pkg::CMD_WAIT;
			else if (kind < 17)
				rq.command = akwwt_pkg::CMD_WAKE;
			else
				rq.command = akwwt_pkg::CMD_RELEASE;
			rq.process_id = pick_pid();
			rq.wait_address = pick_addr();
			rq.op_mode = ($urandom_range(0, 15) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
			rq.expected_generation = ($urandom_range(0, 3) == 0) ? $urandom
				: 32'($urandom_range(0, 3));
			rq.wake_limit = ($urandom_range(0, 4) == 0) ? 8'($urandom)
				: 8'($urandom_range(0, 3));
			rq.waiter_handle = ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom);
			send_request(rq);
		end
		start <= 1'b0;

		// drain, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[address_keyed_wait_wake_table] OK");
		else
			$display("[address_keyed_wait_wake_table] ERROR");
		$finish;
	end

endmodule

[filelist.f]
sv/akwwt_pkg.sv
sv/akwwt_ram.sv
sv/akwwt_ctrl.sv
sv/akwwt_dp.sv
sv/address_keyed_wait_wake_table.sv
tb/address_keyed_wait_wake_table_checker.sv
tb/address_keyed_wait_wake_table_test.sv
